@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the interrupt controller.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/plic_pkg.sv @@
// Types and constants of the platform interrupt controller.
// Used by the controller, the datapath, the top level and the checker.
package plic_pkg;

  localparam int OP_W       = 3;
  localparam int ID_W       = 5;
  localparam int DATA_W     = 32;
  // Sources reachable through a source number or the enable word.
  localparam int SRC_LIMIT  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_SET_PRIO   = 3'd0,
    OP_SET_ENABLE = 3'd1,
    OP_SET_THRESH = 3'd2,
    OP_CLAIM      = 3'd3,
    OP_COMPLETE   = 3'd4,
    OP_RAISE      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } plic_state_t;

  typedef struct packed {
    logic apply;
    logic scan_start;
    logic scan_step;
    logic finish;
  } plic_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } plic_status_t;

endpackage

@@ rtl/platform_interrupt_controller.sv @@
// Channel  Handshake              Payload
// in       in_valid / in_ready    op, source_id, wdata
// out      out_valid / out_ready  claim_id, irq_line
//
// A result is loaded after the priority scan of its transaction, and the next
// transaction can be accepted in the cycle after, so the block does not take a
// new transaction before the last one's result is loaded. The priority scan
// does one memory read and one compare per source except source 0.
// A new transaction is taken while the result register still waits for
// out_ready; its own result then waits until the old one is taken.
// Synchronous reset clears all source state at once through per-entry valid
// bits; no clearing pass is needed.
// Top level of the single-target platform interrupt controller.
// Depends on plic_pkg, plic_ctrl and plic_datapath.
module platform_interrupt_controller import plic_pkg::*; #(
  parameter int NUM_SOURCES   = 32,
  parameter int PRIORITY_BITS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   op,
  input  logic [ID_W-1:0]   source_id,
  input  logic [DATA_W-1:0] wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   claim_id,
  output logic              irq_line
);

  plic_cmd_t    cmd;
  plic_status_t status;

  plic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  plic_datapath #(
    .NUM_SOURCES   (NUM_SOURCES),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .op        (op),
    .source_id (source_id),
    .wdata     (wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .claim_id  (claim_id),
    .irq_line  (irq_line)
  );

endmodule

@@ rtl/plic_ctrl.sv @@
// Controller of the interrupt controller: sequences update, scan and result.
// Depends on plic_pkg; drives the datapath through plic_cmd_t.
module plic_ctrl import plic_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  plic_status_t status,
  output plic_cmd_t    cmd
);

  plic_state_t state;
  plic_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.apply      = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last priority read is compared in this cycle.
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/plic_datapath.sv @@
// Datapath of the interrupt controller: source state, priority memory,
// serial arbitration scan and result register. Depends on plic_pkg.
module plic_datapath import plic_pkg::*; #(
  parameter int NUM_SOURCES   = 32,
  parameter int PRIORITY_BITS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  plic_cmd_t         cmd,
  output plic_status_t      status,
  input  logic [OP_W-1:0]   op,
  input  logic [ID_W-1:0]   source_id,
  input  logic [DATA_W-1:0] wdata,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [ID_W-1:0]   claim_id,
  output logic              irq_line
);

  localparam int NSRC  = (NUM_SOURCES < SRC_LIMIT) ? NUM_SOURCES : SRC_LIMIT;
  localparam int IDX_W = $clog2(NSRC);
  localparam int CNT_W = $clog2(NSRC + 1);

  logic [PRIORITY_BITS-1:0] prio_mem [NSRC];
  logic [NSRC-1:0]          prio_vld;
  logic [NSRC-1:0]          enable;
  logic [NSRC-1:0]          pending;
  logic [NSRC-1:0]          in_service;
  logic [PRIORITY_BITS-1:0] threshold;
  op_t                      op_q;

  logic [CNT_W-1:0]         rd_addr;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic                     rd_ok;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     cmp_vld;
  logic [IDX_W-1:0]         best;
  logic [PRIORITY_BITS-1:0] best_prio;
  logic                     seen_one;
  logic                     seen_two;

  logic                     id_ok;
  logic [IDX_W-1:0]         idx;
  logic [PRIORITY_BITS-1:0] cmp_prio;
  logic                     elig;
  logic                     grant;

  assign id_ok = (source_id != '0) && ({1'b0, source_id} < (ID_W + 1)'(NSRC));
  assign idx   = source_id[IDX_W-1:0];

  assign cmp_prio = rd_ok ? rd_prio : '0;
  assign elig     = cmp_vld && pending[cmp_idx] && enable[cmp_idx] &&
                    (cmp_prio > threshold);
  assign grant    = (op_q == OP_CLAIM) && (best != '0);

  assign status.scan_last = (rd_addr == CNT_W'(NSRC - 1));
  assign status.out_free  = !out_valid || out_ready;

  // Priority storage: written by bus accesses, read once per scan step.
  always_ff @(posedge clk) begin
    if (cmd.apply && (op_t'(op) == OP_SET_PRIO) && id_ok) begin
      prio_mem[idx] <= wdata[PRIORITY_BITS-1:0];
    end
    if (cmd.scan_step) begin
      rd_prio <= prio_mem[rd_addr[IDX_W-1:0]];
      rd_ok   <= prio_vld[rd_addr[IDX_W-1:0]];
      cmp_idx <= rd_addr[IDX_W-1:0];
    end
  end

  // Source state and the effect of each operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      prio_vld   <= '0;
      enable     <= '0;
      pending    <= '0;
      in_service <= '0;
      threshold  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.apply) begin
        case (op_t'(op))
          OP_SET_PRIO: begin
            if (id_ok) begin
              prio_vld[idx] <= 1'b1;
            end
          end
          OP_SET_ENABLE: begin
            enable <= {wdata[NSRC-1:1], 1'b0};
          end
          OP_SET_THRESH: begin
            threshold <= wdata[PRIORITY_BITS-1:0];
          end
          OP_COMPLETE: begin
            if (id_ok && enable[idx]) begin
              in_service[idx] <= 1'b0;
            end
          end
          OP_RAISE: begin
            if (id_ok && !pending[idx] && !in_service[idx]) begin
              pending[idx] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.finish && grant) begin
        pending[best]    <= 1'b0;
        in_service[best] <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Serial arbitration. A strict compare keeps the lowest source on ties;
  // a second eligible source means the line stays up after a claim.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      op_q <= op_t'(op);
    end
    if (cmd.scan_start) begin
      rd_addr   <= CNT_W'(1);
      best      <= '0;
      best_prio <= '0;
      seen_one  <= 1'b0;
      seen_two  <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        rd_addr <= rd_addr + CNT_W'(1);
      end
      if (elig) begin
        seen_one <= 1'b1;
        seen_two <= seen_two || seen_one;
        if (cmp_prio > best_prio) begin
          best      <= cmp_idx;
          best_prio <= cmp_prio;
        end
      end
    end
    if (cmd.finish) begin
      claim_id <= (op_q == OP_CLAIM) ? ID_W'(best) : '0;
      irq_line <= (op_q == OP_CLAIM) ? seen_two : seen_one;
    end
  end

endmodule

@@ rtl/plic_checker.sv @@
// Port-level checker of the interrupt controller, bound to the top level.
// Depends on plic_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plic_checker import plic_pkg::*; #(
  parameter int NUM_SOURCES = 32
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [OP_W-1:0]   op,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ID_W-1:0]   claim_id,
  input logic              irq_line
);

  // Ops of transactions whose results are not yet taken, oldest first.
  logic [OP_W-1:0] head_op;
  logic [OP_W-1:0] tail_op;
  logic [1:0]      cnt;
  logic            push;
  logic            pop;
  logic            head_claim;
  logic            stall;
  logic            nonclaim_out;
  logic            id_fits;
  logic            empty_claim;

  assign push       = in_valid && in_ready;
  assign pop        = out_valid && out_ready;
  assign head_claim = (head_op == OP_CLAIM);

  assign stall        = out_valid && !out_ready;
  assign nonclaim_out = out_valid && !head_claim;
  assign id_fits      = ({1'b0, claim_id} < (ID_W + 1)'(NUM_SOURCES)) ||
                        (NUM_SOURCES > SRC_LIMIT - 1);
  assign empty_claim  = out_valid && head_claim && (claim_id == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case ({push, pop})
        2'b10: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd0) begin
            head_op <= op;
          end else begin
            tail_op <= op;
          end
        end
        2'b01: begin
          cnt     <= cnt - 2'd1;
          head_op <= tail_op;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            head_op <= op;
          end else begin
            head_op <= tail_op;
            tail_op <= op;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, stall, out_valid && $stable({claim_id, irq_line}), "result not held")
  `ASSERT_SAME(a_nonclaim_zero, clk, rst, nonclaim_out, claim_id == '0, "claim_id set for a non-claim")
  `ASSERT_SAME(a_id_range, clk, rst, out_valid, id_fits, "claim_id beyond the source count")
  `ASSERT_SAME(a_empty_claim, clk, rst, empty_claim, !irq_line, "interrupt line high after an empty claim")

endmodule

bind platform_interrupt_controller plic_checker #(
  .NUM_SOURCES (NUM_SOURCES)
) u_plic_checker (.*);
